@@ src/bsf_pkg.sv @@
package bsf_pkg;

  // index field width, fixed by the request format
  localparam int IDX_W = 12;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_TEST  = 2'd2,
    OP_FIND  = 2'd3
  } bsf_op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] bit_index;
  } bsf_in_t;

  typedef struct packed {
    logic             bit_was_set;
    logic [IDX_W-1:0] first_set_index;
    logic             none_found;
  } bsf_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, rewind word counter
    logic rd_word;    // read the addressed word
    logic finish_rw;  // set: write back, test: capture bit
    logic clr_step;   // write zero at counter, advance
    logic scan_step;  // issue next scan read
    logic res_zero;   // result all zero
    logic res_find;   // result from scan hit or miss
    logic out_load;   // move result into output register
  } bsf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last; // counter at last word
    logic hit;        // scanned word has a set bit
    logic scan_end;   // last word scanned and empty
  } bsf_sts_t;

endpackage

@@ src/bitmap_set_test_find_first.sv @@
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (opcode, bit_index)
// out     | output    | out_valid_o / out_stall_i | out_data_o (test, find-first fields)
//
// one request at a time; set and test pass through address, modify and done states,
// clear-all and find-first sweep the word memory through its single read port,
// which is walked one word per cycle
// after reset a clearing pass writes zero to all NUM_WORDS words, in_stall_o high
// an output register holds the result, so a new request is taken while it waits;
// a finished result waits in the result register while the output stays stalled
module bitmap_set_test_find_first import bsf_pkg::*; #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bsf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bsf_out_t out_data_o
);

  bsf_cmd_t cmd;
  bsf_sts_t sts;

  // sequencer: request decode, sweeps, scan, output register control
  bsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (bsf_op_e'(in_data_i.opcode)),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // word memory, index split, scan pipeline, result and output registers
  bsf_dp #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

@@ src/bsf_ram.sv @@
module bsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bsf_ctrl.sv @@
module bsf_ctrl import bsf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  bsf_op_e  in_op_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bsf_cmd_t cmd_o,
  input  bsf_sts_t sts_i
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADDR   = 3'd2;
  localparam logic [2:0] S_MODIFY = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (in_op_i)
            OP_CLEAR: state_d = S_CLEAR;
            OP_SET:   state_d = S_ADDR;
            OP_TEST:  state_d = S_ADDR;
            OP_FIND:  state_d = S_SCAN;
            default:  state_d = S_ADDR;
          endcase
        end
      end
      S_ADDR: begin
        cmd_o.rd_word = 1'b1;
        state_d = S_MODIFY;
      end
      S_MODIFY: begin
        cmd_o.finish_rw = 1'b1;
        state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.res_zero = 1'b1;
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.scan_end) begin
          cmd_o.res_find = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/bsf_dp.sv @@
module bsf_dp import bsf_pkg::*; #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bsf_in_t  in_data_i,
  input  bsf_cmd_t cmd_i,
  output bsf_sts_t sts_o,
  output bsf_out_t out_data_o
);

  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW        = $clog2(NUM_WORDS + 1);
  localparam int PW        = $clog2(WORD_BITS);
  localparam int QW        = IDX_W - PW + 1;
  localparam int RECIP     = (1 << IDX_W) / WORD_BITS;
  localparam int RCW       = $clog2(RECIP + 1);
  localparam int PRW       = IDX_W + RCW;
  localparam int BW        = $clog2(NUM_WORDS * WORD_BITS);

  bsf_op_e          op_q;
  logic [IDX_W-1:0] bit_q;
  logic             in_map_q;
  logic [QW-1:0]    q_est_q;
  logic [AW-1:0]    word_q;
  logic [PW-1:0]    pos_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [BW-1:0]    base_q, base_d;
  logic             chk_vld_q;
  logic             chk_last_q;
  logic [BW-1:0]    chk_base_q;
  bsf_out_t         res_q;
  bsf_out_t         out_q;

  logic [PRW-1:0]       prod;
  logic [IDX_W:0]       qw_mult;
  logic [IDX_W:0]       rem;
  logic [AW-1:0]        word_calc;
  logic [PW-1:0]        pos_calc;
  logic                 cnt_last;
  logic                 scan_issue;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] low_one;
  logic [PW-1:0]        tz;
  logic [31:0]          idx_full;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;

  // quotient estimate by reciprocal, low by at most one
  assign prod = PRW'(in_data_i.bit_index) * PRW'(RECIP);

  // remainder and one correction step
  always_comb begin
    qw_mult = (IDX_W + 1)'(q_est_q) * (IDX_W + 1)'(WORD_BITS);
    rem     = {1'b0, bit_q} - qw_mult;
    if (rem >= (IDX_W + 1)'(WORD_BITS)) begin
      word_calc = AW'(QW'(q_est_q + 1'b1));
      pos_calc  = PW'(rem - (IDX_W + 1)'(WORD_BITS));
    end else begin
      word_calc = AW'(q_est_q);
      pos_calc  = PW'(rem);
    end
  end

  assign cnt_last   = (cnt_q == CW'(NUM_WORDS - 1));
  assign scan_issue = cmd_i.scan_step && (cnt_q < CW'(NUM_WORDS));

  always_comb begin
    cnt_d  = cnt_q;
    base_d = base_q;
    if (cmd_i.load) begin
      cnt_d  = '0;
      base_d = '0;
    end else if (cmd_i.clr_step) begin
      cnt_d = cnt_last ? '0 : CW'(cnt_q + 1'b1);
    end else if (scan_issue) begin
      cnt_d  = CW'(cnt_q + 1'b1);
      base_d = BW'(base_q + BW'(WORD_BITS));
    end
  end

  // lowest set bit: isolate it, then encode the one-hot word
  always_comb begin
    low_one = rdata & (~rdata + WORD_BITS'(1));
    tz      = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (low_one[k]) begin
        tz = tz | PW'(k);
      end
    end
  end

  assign idx_full = 32'(chk_base_q) + 32'(tz);

  assign sts_o.sweep_last = cnt_last;
  assign sts_o.hit        = chk_vld_q && (rdata != '0);
  assign sts_o.scan_end   = chk_vld_q && chk_last_q && (rdata == '0);

  // memory port muxing
  assign ram_we    = cmd_i.clr_step || (cmd_i.finish_rw && (op_q == OP_SET) && in_map_q);
  assign ram_waddr = cmd_i.clr_step ? cnt_q[AW-1:0] : word_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : (rdata | (WORD_BITS'(1) << pos_q));
  assign ram_re    = (cmd_i.rd_word && in_map_q) || scan_issue;
  assign ram_raddr = cmd_i.rd_word ? word_calc : cnt_q[AW-1:0];

  bsf_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      base_q    <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      base_q    <= base_d;
      chk_vld_q <= scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_last_q <= cnt_last;
    chk_base_q <= base_q;
    if (cmd_i.load) begin
      op_q     <= bsf_op_e'(in_data_i.opcode);
      bit_q    <= in_data_i.bit_index;
      in_map_q <= (32'(in_data_i.bit_index) < 32'(MAP_BITS));
      q_est_q  <= QW'(prod >> IDX_W);
    end
    if (cmd_i.rd_word) begin
      word_q <= word_calc;
      pos_q  <= pos_calc;
    end
    if (cmd_i.res_zero) begin
      res_q <= '0;
    end else if (cmd_i.finish_rw) begin
      res_q <= '{bit_was_set:     (op_q == OP_TEST) && in_map_q && rdata[pos_q],
                 first_set_index: '0,
                 none_found:      1'b0};
    end else if (cmd_i.res_find) begin
      if (chk_vld_q && (rdata != '0)) begin
        res_q <= '{bit_was_set:     1'b0,
                   first_set_index: idx_full[IDX_W-1:0],
                   none_found:      1'b0};
      end else begin
        res_q <= '{bit_was_set: 1'b0, first_set_index: '0, none_found: 1'b1};
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ bench/tb_bitmap_set_test_find_first.sv @@
module tb_bitmap_set_test_find_first;
  import bsf_pkg::*;

  localparam int NUM_WORDS  = 64;
  localparam int WORD_BITS  = 64;
  // generous cycle budget: ~1100 transactions plus stalls
  localparam int CYCLE_LIMIT = 400000;
  // longest request (find-first on an empty map) plus some slack
  localparam int DRAIN_CYCLES = NUM_WORDS + 16;
  localparam int PHASE_ITEMS  = 270;

  // typed expectations that can be read off directly
  localparam bsf_out_t RES_ZERO  = '0;
  localparam bsf_out_t RES_EMPTY = '{bit_was_set: 1'b0, first_set_index: '0, none_found: 1'b1};

  typedef struct packed {
    bsf_op_e          op;
    logic [IDX_W-1:0] idx;
    logic             typed;  // 1: use want, 0: use the shadow prediction
    bsf_out_t         want;
  } dir_row_t;

  localparam int DIR_N = 26;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // empty map right after the clearing pass
    '{OP_FIND,  12'd0,    1'b1, RES_EMPTY},
    '{OP_TEST,  12'd0,    1'b1, RES_ZERO},
    '{OP_TEST,  12'd4095, 1'b1, RES_ZERO},
    // top bit only: scan has to walk to the last word
    '{OP_SET,   12'd4095, 1'b1, RES_ZERO},
    '{OP_TEST,  12'd4095, 1'b0, RES_ZERO},
    '{OP_FIND,  12'd0,    1'b0, RES_ZERO},
    // word boundary between words 0 and 1
    '{OP_SET,   12'd64,   1'b1, RES_ZERO},
    '{OP_FIND,  12'd4095, 1'b0, RES_ZERO},
    '{OP_SET,   12'd63,   1'b1, RES_ZERO},
    '{OP_FIND,  12'd0,    1'b0, RES_ZERO},
    '{OP_TEST,  12'd64,   1'b0, RES_ZERO},
    '{OP_TEST,  12'd65,   1'b0, RES_ZERO},
    // setting the same bit twice must leave it set (or, not xor)
    '{OP_SET,   12'd0,    1'b1, RES_ZERO},
    '{OP_SET,   12'd0,    1'b1, RES_ZERO},
    '{OP_TEST,  12'd0,    1'b0, RES_ZERO},
    '{OP_FIND,  12'd0,    1'b0, RES_ZERO},
    // alternating index patterns
    '{OP_SET,   12'd2730, 1'b1, RES_ZERO},
    '{OP_TEST,  12'd2730, 1'b0, RES_ZERO},
    '{OP_TEST,  12'd1365, 1'b0, RES_ZERO},
    // clear-all wipes everything, index ignored
    '{OP_CLEAR, 12'd4095, 1'b1, RES_ZERO},
    '{OP_FIND,  12'd0,    1'b1, RES_EMPTY},
    '{OP_TEST,  12'd4095, 1'b1, RES_ZERO},
    // first bit of the last word
    '{OP_SET,   12'd4032, 1'b1, RES_ZERO},
    '{OP_FIND,  12'd0,    1'b0, RES_ZERO},
    '{OP_CLEAR, 12'd0,    1'b1, RES_ZERO},
    '{OP_TEST,  12'd4032, 1'b1, RES_ZERO}
  };

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  bsf_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bsf_out_t out_data_o;

  // shadow copy of the bit map, updated at each accepted request
  logic [WORD_BITS-1:0] shadow_map [NUM_WORDS];
  // results still owed by the block, oldest first
  bsf_out_t             pending_resp_q [$];
  // indices set since the last clear, used to aim tests at live bits
  logic [IDX_W-1:0]     set_bits_q [$];

  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  int       fail_count    = 0;
  int       cycle_cnt     = 0;
  bsf_out_t head_resp;

  bitmap_set_test_find_first dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 time unit period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // apply one request to the shadow map and return the answer it earns
  function automatic bsf_out_t bitmap_response(input bsf_in_t req);
    bsf_out_t         resp;
    logic [5:0]       word_sel;
    logic [5:0]       bit_sel;
    logic [5:0]       low_pos;
    int               wi;
    int               bi;
    resp     = '0;
    word_sel = req.bit_index[11:6];
    bit_sel  = req.bit_index[5:0];
    case (bsf_op_e'(req.opcode))
      OP_CLEAR: begin
        for (wi = 0; wi < NUM_WORDS; wi++) shadow_map[wi] = '0;
      end
      OP_SET: begin
        // 12-bit index always lands inside a 4096-bit map
        shadow_map[word_sel][bit_sel] = 1'b1;
      end
      OP_TEST: begin
        resp.bit_was_set = shadow_map[word_sel][bit_sel];
      end
      default: begin
        resp.none_found = 1'b1;
        for (wi = 0; wi < NUM_WORDS; wi++) begin
          if (resp.none_found && shadow_map[wi] != '0) begin
            low_pos = '0;
            // walk down so the lowest set position wins
            for (bi = WORD_BITS - 1; bi >= 0; bi--) begin
              if (shadow_map[wi][bi]) low_pos = bi[5:0];
            end
            resp.first_set_index = {wi[5:0], low_pos};
            resp.none_found      = 1'b0;
          end
        end
      end
    endcase
    return resp;
  endfunction

  // present one request transaction, hold it until accepted, log what it owes
  task automatic send_req(input bsf_in_t req, input logic use_typed, input bsf_out_t typed_resp);
    bsf_out_t pred;
    // optional gap; valid drops only when a gap is taken, so it never toggles within a step
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    pred = bitmap_response(req);
    pending_resp_q.push_back(use_typed ? typed_resp : pred);
    if (bsf_op_e'(req.opcode) == OP_SET) set_bits_q.push_back(req.bit_index);
    if (bsf_op_e'(req.opcode) == OP_CLEAR) set_bits_q.delete();
  endtask

  // random traffic: sparse maps between clears, sets packed above a random floor
  // so the scan reaches deep words, tests aimed at live bits and their neighbors
  task automatic run_random_phase(input int n_items);
    bsf_in_t          req;
    int unsigned      roll;
    int unsigned      floor_word;
    logic [IDX_W-1:0] live;
    floor_word = $urandom_range(NUM_WORDS - 1);
    for (int k = 0; k < n_items; k++) begin
      roll          = $urandom_range(99);
      req.bit_index = IDX_W'($urandom_range(4095));
      if (roll < 4) begin
        req.opcode = OP_CLEAR;
        floor_word = $urandom_range(NUM_WORDS - 1);
      end else if (roll < 40) begin
        req.opcode = OP_SET;
        // one in ten sets is uniform noise
        if ($urandom_range(9) != 0)
          req.bit_index = IDX_W'(floor_word * WORD_BITS
                                 + $urandom_range(4095 - floor_word * WORD_BITS));
      end else if (roll < 72) begin
        req.opcode = OP_TEST;
        if (set_bits_q.size() != 0 && $urandom_range(1) == 1) begin
          live          = set_bits_q[$urandom_range(set_bits_q.size() - 1)];
          req.bit_index = ($urandom_range(3) == 0) ? (live ^ 12'd1) : live;
        end
      end else begin
        req.opcode = OP_FIND;
      end
      send_req(req, 1'b0, RES_ZERO);
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker: every accepted result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_resp_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none actual %h",
                 $time, out_data_o);
        fail_count++;
      end else begin
        head_resp = pending_resp_q.pop_front();
        if (out_data_o.bit_was_set !== head_resp.bit_was_set) begin
          $display("%0t: bit_was_set expected %0d actual %0d",
                   $time, head_resp.bit_was_set, out_data_o.bit_was_set);
          fail_count++;
        end
        if (out_data_o.first_set_index !== head_resp.first_set_index) begin
          $display("%0t: first_set_index expected %0d actual %0d",
                   $time, head_resp.first_set_index, out_data_o.first_set_index);
          fail_count++;
        end
        if (out_data_o.none_found !== head_resp.none_found) begin
          $display("%0t: none_found expected %0d actual %0d",
                   $time, head_resp.none_found, out_data_o.none_found);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_resp_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    bsf_in_t req;
    for (int w = 0; w < NUM_WORDS; w++) shadow_map[w] = '0;

    // single reset at the start; the block's clearing pass shows up as in_stall_o
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, no idling
    for (int r = 0; r < DIR_N; r++) begin
      req.opcode    = DIR_TAB[r].op;
      req.bit_index = DIR_TAB[r].idx;
      send_req(req, DIR_TAB[r].typed, DIR_TAB[r].want);
    end
    run_random_phase(PHASE_ITEMS);

    // sender gaps only
    send_idle_pct = 60;
    stall_pct     = 0;
    run_random_phase(PHASE_ITEMS);

    // receiver stalls only
    send_idle_pct = 0;
    stall_pct     = 60;
    run_random_phase(PHASE_ITEMS);

    // both sides idling
    send_idle_pct = 30;
    stall_pct     = 30;
    run_random_phase(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    // catch any stray result after the last one owed
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
